### design/sslw_pkg.sv
// ----------------------------------------------------------------------------
// sslw_pkg: shared types and constants for the source lock watchdog
// Command and source codes, register indexes, and the structs that travel
// between the front queue, the execution stage and the top level.
// ----------------------------------------------------------------------------
package sslw_pkg;

    // Command codes
    localparam logic [1:0] CMD_SAMPLE     = 2'd0;
    localparam logic [1:0] CMD_POLL       = 2'd1;
    localparam logic [1:0] CMD_DISCONNECT = 2'd2;

    // Source codes
    localparam logic [1:0] SRC_NONE     = 2'd0;
    localparam logic [1:0] SRC_WIRELESS = 2'd1;

    // Configuration register indexes
    localparam int unsigned CFG_AW = 3;
    localparam int unsigned CFG_DW = 31;
    localparam logic [CFG_AW-1:0] REG_ENABLED          = 3'd0;
    localparam logic [CFG_AW-1:0] REG_INVALID_DISC_MS  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_WIRELESS_TO_MS   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_OTHER_TO_MS      = 3'd3;
    localparam logic [CFG_AW-1:0] REG_STALE_MS         = 3'd4;

    // Register reset values
    localparam logic [CFG_DW-1:0] RST_INVALID_DISC_MS = 31'd10000;
    localparam logic [CFG_DW-1:0] RST_WIRELESS_TO_MS  = 31'd5000;
    localparam logic [CFG_DW-1:0] RST_OTHER_TO_MS     = 31'd5000;
    localparam logic [CFG_DW-1:0] RST_STALE_MS        = 31'd3000;

    // Held reading value when there is no valid sample
    localparam logic signed [7:0] SPO2_NONE  = -8'sd1;
    localparam logic signed [9:0] PULSE_NONE = -10'sd1;

    typedef struct packed {
        logic              we;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] data;
    } t_cfg_wr;

    // Classified input transaction
    typedef struct packed {
        logic        is_sample;
        logic        is_poll;
        logic        is_disc;
        logic [31:0] now_time;
        logic [1:0]  source_id;
        logic        sample_valid;
        logic [6:0]  sample_spo2;
        logic [8:0]  sample_pulse;
        logic        finger_known;
        logic        finger_on;
    } t_item;

    typedef struct packed {
        logic              accepted;
        logic              action_stale;
        logic              action_disconnect;
        logic              present;
        logic              fresh;
        logic [1:0]        locked_source;
        logic signed [7:0] spo2_out;
        logic signed [9:0] pulse_out;
        logic              reading_ok;
        logic              contact_known_out;
        logic              contact_present_out;
        logic [31:0]       age_ms;
    } t_result;

    // Signed 32-bit span (a - b) below a non-negative limit
    function automatic logic span_below(input logic [31:0] diff,
                                        input logic [CFG_DW-1:0] limit);
        return diff[31] | (diff < {1'b0, limit});
    endfunction

endpackage

### design/sslw_front.sv
// ----------------------------------------------------------------------------
// sslw_front: input queue and command classifier
// Decodes each pushed transaction into a one-hot command kind (none for an
// unknown code) and holds up to two transactions for the execution stage.
// ----------------------------------------------------------------------------
module sslw_front
    import sslw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now_time,
    input  logic [1:0]  i_source_id,
    input  logic        i_sample_valid,
    input  logic [6:0]  i_sample_spo2,
    input  logic [8:0]  i_sample_pulse,
    input  logic        i_sample_contact_known,
    input  logic        i_sample_contact_present,
    output logic        o_item_valid,
    output t_item       o_item,
    input  logic        i_item_take
);

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    logic  w_push_ok;
    logic  w_pop_ok;
    t_item w_item;

    assign o_full       = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_slot[r_rd_ptr];
    assign w_push_ok    = i_push & ~o_full;
    assign w_pop_ok     = i_item_take & o_item_valid;

    // Classify: unknown command codes fall through with no kind bit set
    always_comb begin
        w_item                 = '0;
        unique case (i_command)
            CMD_SAMPLE:     w_item.is_sample = 1'b1;
            CMD_POLL:       w_item.is_poll   = 1'b1;
            CMD_DISCONNECT: w_item.is_disc   = 1'b1;
            default:        ;
        endcase
        w_item.now_time        = i_now_time;
        w_item.source_id       = i_source_id;
        w_item.sample_valid    = i_sample_valid;
        w_item.sample_spo2     = i_sample_spo2;
        w_item.sample_pulse    = i_sample_pulse;
        w_item.finger_known    = i_sample_contact_known;
        w_item.finger_on       = i_sample_contact_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({w_push_ok, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[r_wr_ptr] <= w_item;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("front queue count out of range");

    a_kind_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_valid |-> $onehot0({o_item.is_sample, o_item.is_poll, o_item.is_disc}))
        else $error("front item carries more than one command kind");

endmodule

### design/sslw_back.sv
// ----------------------------------------------------------------------------
// sslw_back: lock state, watchdog timing and result queue
// Holds configuration and lock state, executes one classified transaction
// per cycle while the result queue has room or is popped, and queues up to two results.
// ----------------------------------------------------------------------------
module sslw_back
    import sslw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_take,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    // Configuration
    logic              r_enabled;
    logic [CFG_DW-1:0] r_inv_disc_ms;
    logic [CFG_DW-1:0] r_wl_to_ms;
    logic [CFG_DW-1:0] r_oth_to_ms;
    logic [CFG_DW-1:0] r_stale_ms;

    // Lock state
    logic              r_lock_present, n_lock_present;
    logic [1:0]        r_lock_source,  n_lock_source;
    logic signed [7:0] r_held_spo2,    n_held_spo2;
    logic signed [9:0] r_held_pulse,   n_held_pulse;
    logic [2:0]        r_held_flags,   n_held_flags;
    logic [31:0]       r_last_time,    n_last_time;
    logic [31:0]       r_inv_start,    n_inv_start;

    // Result queue
    t_result    r_res [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    logic        w_fire;
    logic        w_pop_ok;
    logic        w_take;
    logic        w_clear;
    logic        w_wl_src;
    logic [31:0] w_start_eff;
    logic [31:0] w_inv_span;
    logic [31:0] w_last_span;
    logic [31:0] w_age;
    logic [CFG_DW-1:0] w_poll_lim;
    t_result     w_res;

    assign o_empty     = (r_cnt == 2'd0);
    assign o_result    = r_res[r_rd_ptr];
    assign w_pop_ok    = i_pop & ~o_empty;
    assign o_item_take = (r_cnt != 2'd2) | i_pop;
    assign w_fire      = i_item_valid & o_item_take;

    assign w_wl_src    = (i_item.source_id == SRC_WIRELESS);
    assign w_start_eff = (r_inv_start == 32'd0) ? i_item.now_time : r_inv_start;
    assign w_inv_span  = i_item.now_time - w_start_eff;
    assign w_last_span = i_item.now_time - r_last_time;
    assign w_poll_lim  = (r_lock_source == SRC_WIRELESS) ? r_wl_to_ms : r_oth_to_ms;

    // Sample acceptance rule
    assign w_take = r_enabled & (i_item.source_id != SRC_NONE)
                  & ~(r_lock_present & (r_lock_source != i_item.source_id))
                  & ~(~r_lock_present & ~i_item.sample_valid & ~w_wl_src);

    always_comb begin
        n_lock_present = r_lock_present;
        n_lock_source  = r_lock_source;
        n_held_spo2    = r_held_spo2;
        n_held_pulse   = r_held_pulse;
        n_held_flags   = r_held_flags;
        n_last_time    = r_last_time;
        n_inv_start    = r_inv_start;
        w_res          = '0;
        w_clear        = 1'b0;

        priority if (i_item.is_sample) begin
            if (w_take) begin
                w_res.accepted = 1'b1;
                n_lock_present = 1'b1;
                n_lock_source  = i_item.source_id;
                n_last_time    = i_item.now_time;
                n_held_spo2    = i_item.sample_valid ? {1'b0, i_item.sample_spo2}
                                                     : SPO2_NONE;
                n_held_pulse   = i_item.sample_valid ? {1'b0, i_item.sample_pulse}
                                                     : PULSE_NONE;
                n_held_flags   = {i_item.finger_on, i_item.finger_known,
                                  i_item.sample_valid};
                if (!w_wl_src || i_item.sample_valid) begin
                    n_inv_start = 32'd0;
                end else if (!span_below(w_inv_span, r_inv_disc_ms)) begin
                    w_res.action_disconnect = 1'b1;
                    n_inv_start = i_item.now_time;
                end else begin
                    n_inv_start = w_start_eff;
                end
            end
        end else if (i_item.is_poll) begin
            if (r_enabled && r_lock_present && !span_below(w_last_span, w_poll_lim)) begin
                w_res.action_disconnect = (r_lock_source == SRC_WIRELESS);
                w_res.action_stale      = 1'b1;
                w_clear                 = 1'b1;
            end
        end else if (i_item.is_disc) begin
            w_clear = r_lock_present & (r_lock_source == i_item.source_id);
        end else begin
        end

        if (w_clear) begin
            n_lock_present = 1'b0;
            n_lock_source  = SRC_NONE;
            n_held_spo2    = SPO2_NONE;
            n_held_pulse   = PULSE_NONE;
            n_held_flags   = 3'd0;
            n_last_time    = 32'd0;
            n_inv_start    = 32'd0;
        end

        // Snapshot after the update
        w_age                     = i_item.now_time - n_last_time;
        w_res.present             = n_lock_present;
        w_res.fresh               = n_lock_present & span_below(w_age, r_stale_ms);
        w_res.locked_source       = n_lock_source;
        w_res.spo2_out            = n_held_spo2;
        w_res.pulse_out           = n_held_pulse;
        w_res.reading_ok          = n_held_flags[0];
        w_res.contact_known_out   = n_held_flags[1];
        w_res.contact_present_out = n_held_flags[2];
        w_res.age_ms              = n_lock_present ? w_age : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_inv_disc_ms  <= RST_INVALID_DISC_MS;
            r_wl_to_ms     <= RST_WIRELESS_TO_MS;
            r_oth_to_ms    <= RST_OTHER_TO_MS;
            r_stale_ms     <= RST_STALE_MS;
            r_lock_present <= 1'b0;
            r_lock_source  <= SRC_NONE;
            r_held_spo2    <= SPO2_NONE;
            r_held_pulse   <= PULSE_NONE;
            r_held_flags   <= 3'd0;
            r_last_time    <= 32'd0;
            r_inv_start    <= 32'd0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.addr)
                REG_ENABLED: begin
                    r_enabled <= i_cfg.data[0];
                    // Disabling drops the lock and the held reading
                    if (!i_cfg.data[0]) begin
                        r_lock_present <= 1'b0;
                        r_lock_source  <= SRC_NONE;
                        r_held_spo2    <= SPO2_NONE;
                        r_held_pulse   <= PULSE_NONE;
                        r_held_flags   <= 3'd0;
                        r_last_time    <= 32'd0;
                        r_inv_start    <= 32'd0;
                    end
                end
                REG_INVALID_DISC_MS: r_inv_disc_ms <= i_cfg.data;
                REG_WIRELESS_TO_MS:  r_wl_to_ms    <= i_cfg.data;
                REG_OTHER_TO_MS:     r_oth_to_ms   <= i_cfg.data;
                REG_STALE_MS:        r_stale_ms    <= i_cfg.data;
                default:             ;
            endcase
        end else if (w_fire) begin
            r_lock_present <= n_lock_present;
            r_lock_source  <= n_lock_source;
            r_held_spo2    <= n_held_spo2;
            r_held_pulse   <= n_held_pulse;
            r_held_flags   <= n_held_flags;
            r_last_time    <= n_last_time;
            r_inv_start    <= n_inv_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_fire) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({w_fire, w_pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res[r_wr_ptr] <= w_res;
        end
    end

    a_unlocked_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_lock_present |-> (r_lock_source == SRC_NONE) && (r_held_flags == 3'd0))
        else $error("lock state not cleared while unlocked");

    a_stale_drops_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_res.action_stale |=> !r_lock_present)
        else $error("stale poll left the lock in place");

endmodule

### design/sensor_source_lock_watchdog.sv
// ----------------------------------------------------------------------------
// sensor_source_lock_watchdog: oximeter source lock and watchdog
// Locks onto one oximeter source, holds its latest reading, times invalid
// wireless runs and drops sources that go silent.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the command fields and raise push; a transaction
//   is taken at a clock edge with push high and full low. Commands are
//   sample, poll and disconnect notice; an unknown code only reports state.
//   Result channel: while empty is low the oldest result sits on the o_
//   result ports; raise pop to take it. Every command yields one result.
//   Configuration: pulse i_cfg_we with a register index on i_cfg_addr and
//   the value on i_cfg_wdata; the write lands at that edge. Write only while
//   no transaction is in flight. Writing enabled = 0 drops any lock.
//   Path: a transaction is registered in the input queue, then its result in
//   the result queue; only then does it show on the outputs and can be popped.
//   Throughput: one transaction per cycle while the result queue has room;
//   one item is decided in one pass of the execution compare-and-update logic.
//   Stalls: a two-entry result queue lets the execution stage keep going for
//   two results while pop is low; then the two-entry input queue fills and
//   full rises. Nothing is dropped.
//   Reset: synchronous, active low. Both queues empty, lock cleared, held
//   reading set to -1 and registers back to their defaults (disabled).
// ----------------------------------------------------------------------------
module sensor_source_lock_watchdog
    import sslw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    // input queue side
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_command,
    input  logic [31:0]       i_now_time,
    input  logic [1:0]        i_source_id,
    input  logic              i_sample_valid,
    input  logic [6:0]        i_sample_spo2,
    input  logic [8:0]        i_sample_pulse,
    input  logic              i_sample_contact_known,
    input  logic              i_sample_contact_present,
    // result queue side
    output logic              empty,
    input  logic              pop,
    output logic              o_accepted,
    output logic              o_action_stale,
    output logic              o_action_disconnect,
    output logic              o_present,
    output logic              o_fresh,
    output logic [1:0]        o_locked_source,
    output logic signed [7:0] o_spo2_out,
    output logic signed [9:0] o_pulse_out,
    output logic              o_reading_ok,
    output logic              o_contact_known_out,
    output logic              o_contact_present_out,
    output logic [31:0]       o_age_ms
);

    t_cfg_wr w_cfg;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_item_take;
    t_result w_result;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.addr = i_cfg_addr;
    assign w_cfg.data = i_cfg_wdata;

    // Front: classify and queue incoming transactions
    sslw_front u_front (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_push                   (push),
        .o_full                   (full),
        .i_command                (i_command),
        .i_now_time               (i_now_time),
        .i_source_id              (i_source_id),
        .i_sample_valid           (i_sample_valid),
        .i_sample_spo2            (i_sample_spo2),
        .i_sample_pulse           (i_sample_pulse),
        .i_sample_contact_known   (i_sample_contact_known),
        .i_sample_contact_present (i_sample_contact_present),
        .o_item_valid             (w_item_valid),
        .o_item                   (w_item),
        .i_item_take              (w_item_take)
    );

    // Back: execute against the lock state and queue the results
    sslw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_take  (w_item_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_result     (w_result)
    );

    // Unpack the head result onto the result ports
    assign o_accepted            = w_result.accepted;
    assign o_action_stale        = w_result.action_stale;
    assign o_action_disconnect   = w_result.action_disconnect;
    assign o_present             = w_result.present;
    assign o_fresh               = w_result.fresh;
    assign o_locked_source       = w_result.locked_source;
    assign o_spo2_out            = w_result.spo2_out;
    assign o_pulse_out           = w_result.pulse_out;
    assign o_reading_ok          = w_result.reading_ok;
    assign o_contact_known_out   = w_result.contact_known_out;
    assign o_contact_present_out = w_result.contact_present_out;
    assign o_age_ms              = w_result.age_ms;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sensor_source_lock_watchdog
// Drives command transactions through the input queue with random gaps and
// pops result snapshots with random stalls. A behavioral predictor of the
// lock, timer and watchdog rules computes each expected snapshot. Every
// popped snapshot is checked field by field across several register settings.
// ----------------------------------------------------------------------------
module tb;
    import sslw_pkg::*;

    // Codes the package leaves out
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] SRC_WIRED   = 2'd2;
    localparam logic [1:0] SRC_OTHER   = 2'd3;

    localparam logic [CFG_DW-1:0] LIMIT_MAX = 31'h7FFF_FFFF;
    // A result passes through the input queue and the result queue; leave some margin
    localparam int unsigned SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_ms;
        logic [1:0]  source;
        logic        valid;
        logic [6:0]  spo2;
        logic [8:0]  pulse;
        logic        ck;
        logic        cp;
    } cmd_item_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        i_command = '0;
    logic [31:0]       i_now_time = '0;
    logic [1:0]        i_source_id = '0;
    logic              i_sample_valid = 1'b0;
    logic [6:0]        i_sample_spo2 = '0;
    logic [8:0]        i_sample_pulse = '0;
    logic              i_sample_contact_known = 1'b0;
    logic              i_sample_contact_present = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_accepted;
    logic              o_action_stale;
    logic              o_action_disconnect;
    logic              o_present;
    logic              o_fresh;
    logic [1:0]        o_locked_source;
    logic signed [7:0] o_spo2_out;
    logic signed [9:0] o_pulse_out;
    logic              o_reading_ok;
    logic              o_contact_known_out;
    logic              o_contact_present_out;
    logic [31:0]       o_age_ms;

    sensor_source_lock_watchdog u_top (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_addr              (i_cfg_addr),
        .i_cfg_wdata             (i_cfg_wdata),
        .push                    (push),
        .full                    (full),
        .i_command               (i_command),
        .i_now_time              (i_now_time),
        .i_source_id             (i_source_id),
        .i_sample_valid          (i_sample_valid),
        .i_sample_spo2           (i_sample_spo2),
        .i_sample_pulse          (i_sample_pulse),
        .i_sample_contact_known  (i_sample_contact_known),
        .i_sample_contact_present(i_sample_contact_present),
        .empty                   (empty),
        .pop                     (pop),
        .o_accepted              (o_accepted),
        .o_action_stale          (o_action_stale),
        .o_action_disconnect     (o_action_disconnect),
        .o_present               (o_present),
        .o_fresh                 (o_fresh),
        .o_locked_source         (o_locked_source),
        .o_spo2_out              (o_spo2_out),
        .o_pulse_out             (o_pulse_out),
        .o_reading_ok            (o_reading_ok),
        .o_contact_known_out     (o_contact_known_out),
        .o_contact_present_out   (o_contact_present_out),
        .o_age_ms                (o_age_ms)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: register copies and the lock/hold/timer state
    // ------------------------------------------------------------------------
    logic              cfg_enabled   = 1'b0;
    logic [CFG_DW-1:0] cfg_inv_limit = RST_INVALID_DISC_MS;
    logic [CFG_DW-1:0] cfg_wl_limit  = RST_WIRELESS_TO_MS;
    logic [CFG_DW-1:0] cfg_oth_limit = RST_OTHER_TO_MS;
    logic [CFG_DW-1:0] cfg_stale     = RST_STALE_MS;

    logic              lk_present = 1'b0;
    logic [1:0]        lk_source  = SRC_NONE;
    logic signed [7:0] hold_spo2  = SPO2_NONE;
    logic signed [9:0] hold_pulse = PULSE_NONE;
    logic              hold_ok    = 1'b0;
    logic              hold_ck    = 1'b0;
    logic              hold_cp    = 1'b0;
    logic [31:0]       last_ms    = '0;
    logic [31:0]       inv_start  = '0;   // zero means the invalid timer is idle

    // Stimulus and scoreboard storage
    cmd_item_t   cmd_backlog[$];
    t_result     snapshot_q[$];
    cmd_item_t   drive_cmd;
    t_result     got_snap;
    t_result     want_snap;
    logic [31:0] ms_now = '0;

    int unsigned push_gap_pct  = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned err_count     = 0;
    int unsigned cmds_sent     = 0;
    int unsigned snaps_checked = 0;
    int unsigned samples_taken = 0;
    int unsigned stale_drops   = 0;
    int unsigned disc_requests = 0;

    // Signed 32-bit span (a - b) compared against a non-negative limit
    function automatic logic gap_below(input logic [31:0] a, input logic [31:0] b,
                                       input logic [CFG_DW-1:0] limit);
        logic [31:0] d;
        d = a - b;
        return d[31] || (d < {1'b0, limit});
    endfunction

    function automatic void drop_lock();
        lk_present = 1'b0;
        lk_source  = SRC_NONE;
        hold_spo2  = SPO2_NONE;
        hold_pulse = PULSE_NONE;
        hold_ok    = 1'b0;
        hold_ck    = 1'b0;
        hold_cp    = 1'b0;
        last_ms    = '0;
        inv_start  = '0;
    endfunction

    // Advance the predictor by one command and return the snapshot it yields
    function automatic t_result step_watchdog(input cmd_item_t c);
        t_result           r;
        logic              take;
        logic [CFG_DW-1:0] lim;
        r = '0;
        case (c.command)
            CMD_SAMPLE: begin
                take = cfg_enabled && (c.source != SRC_NONE);
                // A locked source shuts out every other source
                if (take && lk_present && lk_source != c.source)
                    take = 1'b0;
                // Only the wireless source may lock with an unusable sample
                if (take && !lk_present && !c.valid && c.source != SRC_WIRELESS)
                    take = 1'b0;
                if (take) begin
                    r.accepted = 1'b1;
                    lk_present = 1'b1;
                    lk_source  = c.source;
                    last_ms    = c.now_ms;
                    hold_spo2  = c.valid ? $signed({1'b0, c.spo2}) : SPO2_NONE;
                    hold_pulse = c.valid ? $signed({1'b0, c.pulse}) : PULSE_NONE;
                    hold_ok    = c.valid;
                    hold_ck    = c.ck;
                    hold_cp    = c.cp;
                    if (c.source != SRC_WIRELESS || c.valid) begin
                        inv_start = '0;
                    end else begin
                        // A run starting at clock zero leaves the timer idle
                        if (inv_start == '0)
                            inv_start = c.now_ms;
                        if (!gap_below(c.now_ms, inv_start, cfg_inv_limit)) begin
                            r.action_disconnect = 1'b1;
                            inv_start = c.now_ms;
                        end
                    end
                end
            end
            CMD_POLL: begin
                if (cfg_enabled && lk_present) begin
                    lim = (lk_source == SRC_WIRELESS) ? cfg_wl_limit : cfg_oth_limit;
                    if (!gap_below(c.now_ms, last_ms, lim)) begin
                        r.action_disconnect = (lk_source == SRC_WIRELESS);
                        r.action_stale = 1'b1;
                        drop_lock();
                    end
                end
            end
            CMD_DISCONNECT: begin
                // Notices act even while disabled, but only on the locked source
                if (lk_present && lk_source == c.source)
                    drop_lock();
            end
            default: ;
        endcase
        r.present             = lk_present;
        r.fresh               = lk_present && gap_below(c.now_ms, last_ms, cfg_stale);
        r.locked_source       = lk_source;
        r.spo2_out            = hold_spo2;
        r.pulse_out           = hold_pulse;
        r.reading_ok          = hold_ok;
        r.contact_known_out   = hold_ck;
        r.contact_present_out = hold_cp;
        r.age_ms              = lk_present ? (c.now_ms - last_ms) : 32'd0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("snapshot %0d %s: got 0x%0h, want 0x%0h",
                                      snaps_checked, name, got, want));
    endtask

    task automatic compare_snapshot(input t_result got, input t_result want);
        check_field("accepted",        32'(got.accepted),            32'(want.accepted));
        check_field("action_stale",    32'(got.action_stale),        32'(want.action_stale));
        check_field("action_disc",     32'(got.action_disconnect),
                    32'(want.action_disconnect));
        check_field("present",         32'(got.present),             32'(want.present));
        check_field("fresh",           32'(got.fresh),               32'(want.fresh));
        check_field("locked_source",   32'(got.locked_source),       32'(want.locked_source));
        check_field("spo2_out",        32'(got.spo2_out),            32'(want.spo2_out));
        check_field("pulse_out",       32'(got.pulse_out),           32'(want.pulse_out));
        check_field("reading_ok",      32'(got.reading_ok),          32'(want.reading_ok));
        check_field("contact_known_out", 32'(got.contact_known_out),
                    32'(want.contact_known_out));
        check_field("contact_present_out", 32'(got.contact_present_out),
                    32'(want.contact_present_out));
        check_field("age_ms",          got.age_ms,                   want.age_ms);
    endtask

    // ------------------------------------------------------------------------
    // Driver: hold the current transaction until it is taken, then advance
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            // Predict at the acceptance edge so the predictor sees commands in order
            if (push && !full) begin
                snapshot_q.push_back(step_watchdog(drive_cmd));
                cmds_sent++;
            end
            // Load the next transaction once the port is free; insert random gaps
            if (!push || !full) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= push_gap_pct) begin
                    drive_cmd = cmd_backlog.pop_front();
                    i_command                <= drive_cmd.command;
                    i_now_time               <= drive_cmd.now_ms;
                    i_source_id              <= drive_cmd.source;
                    i_sample_valid           <= drive_cmd.valid;
                    i_sample_spo2            <= drive_cmd.spo2;
                    i_sample_pulse           <= drive_cmd.pulse;
                    i_sample_contact_known   <= drive_cmd.ck;
                    i_sample_contact_present <= drive_cmd.cp;
                    push                     <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take each popped snapshot and check it against the oldest one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got_snap.accepted            = o_accepted;
                got_snap.action_stale        = o_action_stale;
                got_snap.action_disconnect   = o_action_disconnect;
                got_snap.present             = o_present;
                got_snap.fresh               = o_fresh;
                got_snap.locked_source       = o_locked_source;
                got_snap.spo2_out            = o_spo2_out;
                got_snap.pulse_out           = o_pulse_out;
                got_snap.reading_ok          = o_reading_ok;
                got_snap.contact_known_out   = o_contact_known_out;
                got_snap.contact_present_out = o_contact_present_out;
                got_snap.age_ms              = o_age_ms;
                if (snapshot_q.size() == 0) begin
                    report_mismatch("snapshot popped with none outstanding");
                end else begin
                    want_snap = snapshot_q.pop_front();
                    compare_snapshot(got_snap, want_snap);
                    samples_taken += want_snap.accepted;
                    stale_drops   += want_snap.action_stale;
                    disc_requests += want_snap.action_disconnect;
                end
                snaps_checked++;
            end
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Write one register at an edge and mirror it in the predictor
    task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ENABLED: begin
                cfg_enabled = val[0];
                if (!val[0])
                    drop_lock();
            end
            REG_INVALID_DISC_MS: cfg_inv_limit = val;
            REG_WIRELESS_TO_MS:  cfg_wl_limit  = val;
            REG_OTHER_TO_MS:     cfg_oth_limit = val;
            REG_STALE_MS:        cfg_stale     = val;
            default: ;
        endcase
    endtask

    // Wait until every transaction is sent and every snapshot checked
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || push || snapshot_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_cmd(input logic [1:0] cmd, input logic [31:0] now,
                           input logic [1:0] src, input logic valid,
                           input logic [6:0] spo2, input logic [8:0] pulse,
                           input logic ck, input logic cp);
        cmd_item_t c;
        c = '{cmd, now, src, valid, spo2, pulse, ck, cp};
        cmd_backlog.push_back(c);
    endtask

    function automatic cmd_item_t random_fields();
        cmd_item_t c;
        c.command = 2'($urandom_range(3));
        c.now_ms  = $urandom;
        c.source  = 2'($urandom_range(3));
        c.valid   = 1'($urandom_range(1));
        c.spo2    = 7'($urandom_range(100));
        c.pulse   = 9'($urandom_range(511));
        c.ck      = 1'($urandom_range(1));
        c.cp      = 1'($urandom_range(1));
        return c;
    endfunction

    // Move the millisecond clock: mostly small forward steps on the scale of
    // the current limits, plus backward steps, half-range jumps, returns to zero and random jumps
    function automatic logic [31:0] advance_clock(input int unsigned scale);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            ms_now = ms_now + 32'($urandom_range(0, 2 * scale));
        else if (r < 86)
            ms_now = ms_now - 32'($urandom_range(0, scale));
        else if (r < 92)
            ms_now = ms_now + 32'h7FFF_FFFE + 32'($urandom_range(2));
        else if (r < 96)
            ms_now = '0;
        else
            ms_now = $urandom;
        return ms_now;
    endfunction

    // A burst centered on one favored source: samples with invalid runs,
    // polls, notices and unknown codes, with some noise from other sources
    task automatic add_burst(input int unsigned scale, input int unsigned n);
        cmd_item_t   c;
        logic [1:0]  fav;
        int unsigned r;
        fav = $urandom_range(1) ? SRC_WIRELESS : 2'($urandom_range(1, 3));
        repeat (n) begin
            c = random_fields();
            c.now_ms = advance_clock(scale);
            r = $urandom_range(99);
            if (r < 55) begin
                c.command = CMD_SAMPLE;
                if ($urandom_range(3) != 0)
                    c.source = fav;
                c.valid = ($urandom_range(99) < 55);
            end else if (r < 80) begin
                c.command = CMD_POLL;
            end else if (r < 92) begin
                c.command = CMD_DISCONNECT;
                if ($urandom_range(9) < 7)
                    c.source = fav;
            end else if (r < 96) begin
                c.command = CMD_UNKNOWN;
            end else begin
                c.command = CMD_SAMPLE;
            end
            cmd_backlog.push_back(c);
        end
    endtask

    task automatic add_random(input int unsigned scale, input int unsigned n);
        int unsigned added;
        int unsigned k;
        added = 0;
        while (added < n) begin
            k = $urandom_range(4, 20);
            // Trim the last burst so the total lands on n
            if (k > n - added)
                k = n - added;
            add_burst(scale, k);
            added += k;
        end
    endtask

    // Drop the lock, load a register set, re-enable and run random traffic
    task automatic run_setting(input logic [CFG_DW-1:0] inv, input logic [CFG_DW-1:0] wl,
                               input logic [CFG_DW-1:0] oth, input logic [CFG_DW-1:0] stale,
                               input int unsigned scale, input int unsigned n);
        set_reg(REG_ENABLED, 31'd0);
        set_reg(REG_INVALID_DISC_MS, inv);
        set_reg(REG_WIRELESS_TO_MS, wl);
        set_reg(REG_OTHER_TO_MS, oth);
        set_reg(REG_STALE_MS, stale);
        set_reg(REG_ENABLED, 31'd1);
        add_random(scale, n);
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles often less than the receiver stalls
        push_gap_pct  = 17;
        pop_stall_pct = 47;

        // Disabled after reset: samples rejected, polls and notices inert
        add_cmd(CMD_SAMPLE,     32'd100, SRC_WIRED, 1'b1, 7'd95, 9'd72, 1'b1, 1'b1);
        add_cmd(CMD_POLL,       32'd200, SRC_NONE,  1'b0, 7'd0,  9'd0,  1'b0, 1'b0);
        add_cmd(CMD_DISCONNECT, 32'd300, SRC_WIRED, 1'b0, 7'd0,  9'd0,  1'b0, 1'b0);
        wait_idle();
        set_reg(REG_ENABLED, 31'd1);

        // Lock rules on a wired source, then timeout without a disconnect request
        add_cmd(CMD_SAMPLE,     32'd1000, SRC_NONE,     1'b1, 7'd97,  9'd70,  1'b1, 1'b1);
        add_cmd(CMD_SAMPLE,     32'd1000, SRC_WIRED,    1'b0, 7'd50,  9'd50,  1'b1, 1'b0);
        add_cmd(CMD_SAMPLE,     32'd1000, SRC_WIRED,    1'b1, 7'd100, 9'd511, 1'b1, 1'b1);
        add_cmd(CMD_SAMPLE,     32'd1100, SRC_WIRELESS, 1'b1, 7'd90,  9'd60,  1'b0, 1'b0);
        add_cmd(CMD_SAMPLE,     32'd2000, SRC_WIRED,    1'b0, 7'd127, 9'd300, 1'b0, 1'b1);
        add_cmd(CMD_POLL,       32'd4000, SRC_NONE,     1'b0, 7'd0,   9'd0,   1'b0, 1'b0);
        add_cmd(CMD_UNKNOWN,    32'd4500, SRC_WIRED,    1'b1, 7'd1,   9'd1,   1'b1, 1'b1);
        add_cmd(CMD_DISCONNECT, 32'd4600, SRC_OTHER,    1'b0, 7'd0,   9'd0,   1'b0, 1'b0);
        add_cmd(CMD_DISCONNECT, 32'd4700, SRC_NONE,     1'b0, 7'd0,   9'd0,   1'b0, 1'b0);
        add_cmd(CMD_POLL,       32'd7000, SRC_NONE,     1'b0, 7'd0,   9'd0,   1'b0, 1'b0);
        // Wireless invalid run starting at clock zero, then reaching the limit
        add_cmd(CMD_SAMPLE,     32'd0,     SRC_WIRELESS, 1'b0, 7'd10, 9'd20, 1'b0, 1'b0);
        add_cmd(CMD_SAMPLE,     32'd5000,  SRC_WIRELESS, 1'b0, 7'd10, 9'd20, 1'b1, 1'b0);
        add_cmd(CMD_SAMPLE,     32'd15000, SRC_WIRELESS, 1'b0, 7'd10, 9'd20, 1'b1, 1'b1);
        add_cmd(CMD_SAMPLE,     32'd16000, SRC_WIRELESS, 1'b1, 7'd0,  9'd0,  1'b1, 1'b1);
        add_cmd(CMD_POLL,       32'd21000, SRC_NONE,     1'b0, 7'd0,  9'd0,  1'b0, 1'b0);
        // Notice naming the locked wireless source
        add_cmd(CMD_SAMPLE,     32'd22000, SRC_WIRELESS, 1'b1, 7'd98, 9'd60, 1'b1, 1'b0);
        add_cmd(CMD_DISCONNECT, 32'd22100, SRC_WIRELESS, 1'b0, 7'd0,  9'd0,  1'b0, 1'b0);
        // Age across the clock wrap, then a half-range jump
        add_cmd(CMD_SAMPLE,     32'hFFFF_FFF0, SRC_OTHER, 1'b1, 7'd90, 9'd80, 1'b0, 1'b1);
        add_cmd(CMD_POLL,       32'd5,         SRC_NONE,  1'b0, 7'd0,  9'd0,  1'b0, 1'b0);
        add_cmd(CMD_POLL,       32'h7FFF_0000, SRC_NONE,  1'b0, 7'd0,  9'd0,  1'b0, 1'b0);
        wait_idle();

        // Random traffic under several register settings
        ms_now = $urandom;
        run_setting(RST_INVALID_DISC_MS, RST_WIRELESS_TO_MS, RST_OTHER_TO_MS,
                    RST_STALE_MS, 3000, 140);
        run_setting(31'd0, 31'd0, 31'd0, 31'd0, 4, 140);

        // Swap: sender idles often, receiver rarely stalls
        push_gap_pct  = 47;
        pop_stall_pct = 17;
        run_setting(31'd40, 31'd25, 31'd60, 31'd15, 30, 140);
        run_setting(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX, 1000, 140);

        // No idling on either side
        push_gap_pct  = 0;
        pop_stall_pct = 0;
        run_setting(31'($urandom_range(1, 20000)), 31'($urandom_range(1, 20000)),
                    31'($urandom_range(1, 20000)), 31'($urandom_range(1, 20000)),
                    5000, 140);
        // Disabled block: only notices can act, and there is no lock to clear
        set_reg(REG_ENABLED, 31'd0);
        add_random(3000, 30);
        wait_idle();
        run_setting(31'd1, LIMIT_MAX, 31'd0, LIMIT_MAX, 500, 110);

        $display("Summary: %0d commands driven, %0d snapshots checked over 6 settings",
                 cmds_sent, snaps_checked);
        $display("Summary: %0d samples locked/held, %0d stale drops, %0d disconnect requests",
                 samples_taken, stale_drops, disc_requests);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: fail the run if it does not finish in time
    initial begin
        #2_000_000;
        $display("Timeout: %0d snapshots still outstanding", snapshot_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
design/sslw_pkg.sv
design/sslw_front.sv
design/sslw_back.sv
design/sensor_source_lock_watchdog.sv
tb/tb.sv
